// ===== sv/php_pkg.sv =====
// shared constants and types of the ph probe compensation block
`default_nettype none

package php_pkg;

  // field widths
  localparam int VoltW   = 20;
  localparam int TempW   = 15;
  localparam int CoefW   = 24;
  localparam int PhW     = 20;
  localparam int CatW    = 2;
  localparam int FracW   = 16;
  localparam int KcW     = 16;
  localparam int MagW    = 19;
  localparam int NumW    = 34;
  localparam int QuoW    = 21;
  localparam int RawW    = 64;
  localparam int RefKW   = 15;
  localparam int CfgIdxW = 2;

  // pipeline shape
  localparam int PolyStages       = 6;
  localparam int DivStepsPerStage = 3;
  localparam int DivStages        = QuoW / DivStepsPerStage;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgCoefA = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCoefB = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCoefC = 2'd2;

  localparam logic [CoefW-1:0] CoefCReset = 24'd458752;

  // ph thresholds, q4.16
  localparam logic [PhW-1:0] PhSix      = 20'd393216;
  localparam logic [PhW-1:0] PhSeven    = 20'd458752;
  localparam logic [PhW-1:0] PhEight    = 20'd524288;
  localparam logic [PhW-1:0] PhFourteen = 20'd917504;

  // 14.0 in q.48 and one half lsb of q.16 in q.48
  localparam logic [RawW-1:0]         RawMax    = 64'h000E_0000_0000_0000;
  localparam logic [2*FracW+PhW:0]    RoundHalf = 53'h0_0000_8000_0000;

  // kelvin offsets in hundredths
  localparam logic [KcW:0]     KelvinCenti = 17'd27315;
  localparam logic [RefKW-1:0] RefKCenti   = 15'd29815;

  typedef enum logic [CatW-1:0] {
    CatError   = 2'd0,
    CatAcid    = 2'd1,
    CatNeutral = 2'd2,
    CatBase    = 2'd3
  } cat_e;

  typedef struct packed {
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
  } coef_t;

  typedef struct packed {
    logic signed [VoltW-1:0] voltage;
    logic                    sample_error;
    logic signed [TempW-1:0] temperature_centi;
  } sample_t;

  // dividend, divisor and sign handed to the divider
  typedef struct packed {
    logic [NumW-1:0] num;
    logic [KcW-1:0]  kc;
    logic            neg;
    logic            err;
  } num_t;

  typedef struct packed {
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            err;
  } quo_t;

endpackage

`default_nettype wire

// ===== sv/php_ifs.sv =====
// request and result channel interfaces of the ph probe compensation block
`default_nettype none

interface php_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [php_pkg::VoltW-1:0] voltage;
  logic                             sample_error;
  logic signed [php_pkg::TempW-1:0] temperature_centi;

  modport source (output valid, voltage, sample_error, temperature_centi, input ready);
  modport sink   (input valid, voltage, sample_error, temperature_centi, output ready);
endinterface

interface php_out_if;
  logic                        valid;
  logic                        ready;
  logic [php_pkg::PhW-1:0]     ph_value;
  logic [php_pkg::CatW-1:0]    category;

  modport source (output valid, ph_value, category, input ready);
  modport sink   (input valid, ph_value, category, output ready);
endinterface

`default_nettype wire

// ===== sv/php_poly.sv =====
// calibration polynomial, clamp, rounding and nernst dividend pipeline
`default_nettype none

module php_poly (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  php_pkg::coef_t   coef_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  php_pkg::sample_t sample_i,
  output logic             valid_o,
  input  logic             ready_i,
  output php_pkg::num_t    num_o
);

  logic [php_pkg::PolyStages-1:0] v_q;
  logic [php_pkg::PolyStages-1:0] stage_rdy;

  logic [php_pkg::KcW-1:0] kc_q  [php_pkg::PolyStages];
  logic                    err_q [php_pkg::PolyStages];

  // stage 1
  logic signed [2*php_pkg::VoltW-1:0]             sq_full;
  logic [2*php_pkg::VoltW-2:0]                    vv_d, vv_q;
  logic signed [php_pkg::CoefW+php_pkg::VoltW-1:0] bv_d, bv1_q, bv2_q;
  logic [php_pkg::KcW:0]                          kc_sum;
  // stage 2
  logic signed [php_pkg::CoefW+php_pkg::VoltW:0]   pa_lo_d, pa_lo_q;
  logic signed [php_pkg::CoefW+php_pkg::VoltW-1:0] pa_hi_d, pa_hi_q;
  // stage 3
  logic signed [php_pkg::RawW-1:0] raw_d, raw_q;
  // stage 4
  logic [2*php_pkg::FracW+php_pkg::PhW:0] rnd;
  logic [php_pkg::PhW-1:0]                raw16_d, raw16_q;
  // stage 5
  logic [php_pkg::PhW-1:0]   diff;
  logic [php_pkg::MagW-1:0]  mag_d, mag_q;
  logic                      neg_d, neg5_q, neg6_q;
  // stage 6
  logic [php_pkg::NumW-1:0]  num_d, num_q;

  // a stage takes new data when empty or when the next one moves on
  always_comb begin
    stage_rdy[php_pkg::PolyStages-1] = !v_q[php_pkg::PolyStages-1] || ready_i;
    for (int k = php_pkg::PolyStages - 2; k >= 0; k--) begin
      stage_rdy[k] = !v_q[k] || stage_rdy[k+1];
    end
  end

  assign ready_o = stage_rdy[0];
  assign valid_o = v_q[php_pkg::PolyStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < php_pkg::PolyStages; k++) begin
        if (stage_rdy[k]) begin
          if (k == 0) begin
            v_q[k] <= valid_i;
          end else begin
            v_q[k] <= v_q[k-1];
          end
        end
      end
    end
  end

  // stage 1: square of the voltage, linear term, kelvin temperature
  always_comb begin
    sq_full = sample_i.voltage * sample_i.voltage;
    vv_d    = sq_full[2*php_pkg::VoltW-2:0];
    bv_d    = coef_i.b * sample_i.voltage;
    kc_sum  = {{(php_pkg::KcW+1-php_pkg::TempW){sample_i.temperature_centi[php_pkg::TempW-1]}},
               sample_i.temperature_centi} + php_pkg::KelvinCenti;
  end

  // stage 2: quadratic term in two halves
  always_comb begin
    pa_lo_d = coef_i.a * $signed({1'b0, vv_q[php_pkg::VoltW-1:0]});
    pa_hi_d = coef_i.a * $signed({1'b0, vv_q[2*php_pkg::VoltW-2:php_pkg::VoltW]});
  end

  // stage 3: exact raw ph in q.48
  always_comb begin
    raw_d = $signed({pa_hi_q, {php_pkg::VoltW{1'b0}}})
          + $signed({{(php_pkg::RawW-php_pkg::CoefW-php_pkg::VoltW-1)
                       {pa_lo_q[php_pkg::CoefW+php_pkg::VoltW]}}, pa_lo_q})
          + $signed({{(php_pkg::RawW-php_pkg::CoefW-php_pkg::VoltW-php_pkg::FracW)
                       {bv2_q[php_pkg::CoefW+php_pkg::VoltW-1]}},
                     bv2_q, {php_pkg::FracW{1'b0}}})
          + $signed({{(php_pkg::RawW-php_pkg::CoefW-2*php_pkg::FracW)
                       {coef_i.c[php_pkg::CoefW-1]}},
                     coef_i.c, {(2*php_pkg::FracW){1'b0}}});
  end

  // stage 4: clamp to 0..14 and round to q.16
  always_comb begin
    rnd = {1'b0, raw_q[2*php_pkg::FracW+php_pkg::PhW-1:0]} + php_pkg::RoundHalf;
    if (raw_q[php_pkg::RawW-1]) begin
      raw16_d = '0;
    end else if ($unsigned(raw_q) > php_pkg::RawMax) begin
      raw16_d = php_pkg::PhFourteen;
    end else begin
      raw16_d = rnd[2*php_pkg::FracW+php_pkg::PhW-1:2*php_pkg::FracW];
    end
  end

  // stage 5: offset from neutral as sign and magnitude
  always_comb begin
    neg_d = raw16_q < php_pkg::PhSeven;
    if (neg_d) begin
      diff = php_pkg::PhSeven - raw16_q;
    end else begin
      diff = raw16_q - php_pkg::PhSeven;
    end
    mag_d = diff[php_pkg::MagW-1:0];
  end

  // stage 6: scaled magnitude plus half the divisor
  always_comb begin
    num_d = {{(php_pkg::NumW-php_pkg::MagW){1'b0}}, mag_q}
          * {{(php_pkg::NumW-php_pkg::RefKW){1'b0}}, php_pkg::RefKCenti}
          + {{(php_pkg::NumW-php_pkg::KcW+1){1'b0}}, kc_q[4][php_pkg::KcW-1:1]};
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[0]) begin
      vv_q     <= vv_d;
      bv1_q    <= bv_d;
      kc_q[0]  <= kc_sum[php_pkg::KcW-1:0];
      err_q[0] <= sample_i.sample_error;
    end
    if (stage_rdy[1]) begin
      pa_lo_q  <= pa_lo_d;
      pa_hi_q  <= pa_hi_d;
      bv2_q    <= bv1_q;
    end
    if (stage_rdy[2]) begin
      raw_q    <= raw_d;
    end
    if (stage_rdy[3]) begin
      raw16_q  <= raw16_d;
    end
    if (stage_rdy[4]) begin
      mag_q    <= mag_d;
      neg5_q   <= neg_d;
    end
    if (stage_rdy[5]) begin
      num_q    <= num_d;
      neg6_q   <= neg5_q;
    end
    for (int k = 1; k < php_pkg::PolyStages; k++) begin
      if (stage_rdy[k]) begin
        kc_q[k]  <= kc_q[k-1];
        err_q[k] <= err_q[k-1];
      end
    end
  end

  assign num_o = '{num: num_q, kc: kc_q[php_pkg::PolyStages-1], neg: neg6_q,
                   err: err_q[php_pkg::PolyStages-1]};

endmodule

`default_nettype wire

// ===== sv/php_div.sv =====
// pipelined restoring divider, a few quotient bits per stage
`default_nettype none

module php_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  php_pkg::num_t num_i,
  output logic          valid_o,
  input  logic          ready_i,
  output php_pkg::quo_t quo_o
);

  logic [php_pkg::DivStages-1:0] v_q;
  logic [php_pkg::DivStages-1:0] stage_rdy;

  logic [php_pkg::KcW-1:0]  rem_q  [php_pkg::DivStages];
  logic [php_pkg::QuoW-1:0] bits_q [php_pkg::DivStages];
  logic [php_pkg::QuoW-1:0] quo_q  [php_pkg::DivStages];
  logic [php_pkg::KcW-1:0]  kc_q   [php_pkg::DivStages];
  logic                     neg_q  [php_pkg::DivStages];
  logic                     err_q  [php_pkg::DivStages];

  logic [php_pkg::KcW-1:0]  src_rem  [php_pkg::DivStages];
  logic [php_pkg::QuoW-1:0] src_bits [php_pkg::DivStages];
  logic [php_pkg::QuoW-1:0] src_quo  [php_pkg::DivStages];
  logic [php_pkg::KcW-1:0]  src_kc   [php_pkg::DivStages];
  logic                     src_neg  [php_pkg::DivStages];
  logic                     src_err  [php_pkg::DivStages];

  logic [php_pkg::KcW-1:0]  rem_d  [php_pkg::DivStages];
  logic [php_pkg::QuoW-1:0] bits_d [php_pkg::DivStages];
  logic [php_pkg::QuoW-1:0] quo_d  [php_pkg::DivStages];

  logic [php_pkg::KcW-1:0]  rem_w;
  logic [php_pkg::QuoW-1:0] bits_w;
  logic [php_pkg::QuoW-1:0] quo_w;
  logic [php_pkg::KcW:0]    trial;
  logic [php_pkg::KcW:0]    less;

  always_comb begin
    stage_rdy[php_pkg::DivStages-1] = !v_q[php_pkg::DivStages-1] || ready_i;
    for (int k = php_pkg::DivStages - 2; k >= 0; k--) begin
      stage_rdy[k] = !v_q[k] || stage_rdy[k+1];
    end
  end

  assign ready_o = stage_rdy[0];
  assign valid_o = v_q[php_pkg::DivStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < php_pkg::DivStages; k++) begin
        if (stage_rdy[k]) begin
          if (k == 0) begin
            v_q[k] <= valid_i;
          end else begin
            v_q[k] <= v_q[k-1];
          end
        end
      end
    end
  end

  // top dividend bits start as the remainder, they are always below the divisor
  always_comb begin
    src_rem[0]  = {{(php_pkg::KcW-php_pkg::NumW+php_pkg::QuoW){1'b0}},
                   num_i.num[php_pkg::NumW-1:php_pkg::QuoW]};
    src_bits[0] = num_i.num[php_pkg::QuoW-1:0];
    src_quo[0]  = '0;
    src_kc[0]   = num_i.kc;
    src_neg[0]  = num_i.neg;
    src_err[0]  = num_i.err;
    for (int k = 1; k < php_pkg::DivStages; k++) begin
      src_rem[k]  = rem_q[k-1];
      src_bits[k] = bits_q[k-1];
      src_quo[k]  = quo_q[k-1];
      src_kc[k]   = kc_q[k-1];
      src_neg[k]  = neg_q[k-1];
      src_err[k]  = err_q[k-1];
    end
  end

  // shift one dividend bit in, subtract the divisor when it fits
  always_comb begin
    rem_w  = '0;
    bits_w = '0;
    quo_w  = '0;
    trial  = '0;
    less   = '0;
    for (int k = 0; k < php_pkg::DivStages; k++) begin
      rem_w  = src_rem[k];
      bits_w = src_bits[k];
      quo_w  = src_quo[k];
      for (int j = 0; j < php_pkg::DivStepsPerStage; j++) begin
        trial  = {rem_w, bits_w[php_pkg::QuoW-1]};
        bits_w = {bits_w[php_pkg::QuoW-2:0], 1'b0};
        less   = trial - {1'b0, src_kc[k]};
        if (trial >= {1'b0, src_kc[k]}) begin
          rem_w = less[php_pkg::KcW-1:0];
          quo_w = {quo_w[php_pkg::QuoW-2:0], 1'b1};
        end else begin
          rem_w = trial[php_pkg::KcW-1:0];
          quo_w = {quo_w[php_pkg::QuoW-2:0], 1'b0};
        end
      end
      rem_d[k]  = rem_w;
      bits_d[k] = bits_w;
      quo_d[k]  = quo_w;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < php_pkg::DivStages; k++) begin
      if (stage_rdy[k]) begin
        rem_q[k]  <= rem_d[k];
        bits_q[k] <= bits_d[k];
        quo_q[k]  <= quo_d[k];
        kc_q[k]   <= src_kc[k];
        neg_q[k]  <= src_neg[k];
        err_q[k]  <= src_err[k];
      end
    end
  end

  assign quo_o = '{quo: quo_q[php_pkg::DivStages-1], neg: neg_q[php_pkg::DivStages-1],
                   err: err_q[php_pkg::DivStages-1]};

endmodule

`default_nettype wire

// ===== sv/ph_probe_temperature_compensation.sv =====
// top level of the ph probe reading with nernst temperature compensation
//
//   channel   dir  handshake     payload
//   in_i      in   valid/ready   voltage q3.16, sample_error, temperature_centi
//   out_o     out  valid/ready   ph_value q4.16, category
//   cfg_*     in   cfg_we_i      cfg_idx_i, cfg_wdata_i (coef_a, coef_b, coef_c)
//
// one request accepted per cycle while the output is not stalled; the result
// passes six stages of polynomial, clamp and scaling, seven divider stages of
// three quotient bits each, and the output register
// rst_ni clears the valid bits and loads the coefficient reset values
// a stalled output holds the pipeline back stage by stage; empty stages
// still fill, so requests are taken until every stage holds data
`default_nettype none

module ph_probe_temperature_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [php_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [php_pkg::CoefW-1:0]     cfg_wdata_i,
  php_in_if.sink                        in_i,
  php_out_if.source                     out_o
);

  // calibration coefficients
  php_pkg::coef_t   coef_q;

  php_pkg::sample_t sample;
  php_pkg::num_t    num;
  php_pkg::quo_t    quo;

  logic poly_valid, div_ready;
  logic div_valid, out_rdy;

  // output register
  logic                    out_v_q;
  logic [php_pkg::PhW-1:0] ph_d, ph_q;
  php_pkg::cat_e           cat_d, cat_q;

  // register writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.a <= '0;
      coef_q.b <= '0;
      coef_q.c <= php_pkg::CoefCReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        php_pkg::CfgCoefA: coef_q.a <= cfg_wdata_i;
        php_pkg::CfgCoefB: coef_q.b <= cfg_wdata_i;
        php_pkg::CfgCoefC: coef_q.c <= cfg_wdata_i;
        default: coef_q <= coef_q;
      endcase
    end
  end

  assign sample = '{voltage: in_i.voltage, sample_error: in_i.sample_error,
                    temperature_centi: in_i.temperature_centi};

  // raw ph, clamp, round, offset from neutral times reference kelvin
  php_poly u_poly (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coef_i   (coef_q),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .sample_i (sample),
    .valid_o  (poly_valid),
    .ready_i  (div_ready),
    .num_o    (num)
  );

  // divide by the actual kelvin temperature, half already added for rounding
  php_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (poly_valid),
    .ready_o (div_ready),
    .num_i   (num),
    .valid_o (div_valid),
    .ready_i (out_rdy),
    .quo_o   (quo)
  );

  // restore the sign around neutral, clamp to 0..14 and classify
  always_comb begin
    if (quo.neg) begin
      if (quo.quo >= {1'b0, php_pkg::PhSeven}) begin
        ph_d = '0;
      end else begin
        ph_d = php_pkg::PhSeven - quo.quo[php_pkg::PhW-1:0];
      end
    end else begin
      if (quo.quo >= {1'b0, php_pkg::PhSeven}) begin
        ph_d = php_pkg::PhFourteen;
      end else begin
        ph_d = php_pkg::PhSeven + quo.quo[php_pkg::PhW-1:0];
      end
    end

    if (ph_d < php_pkg::PhSix) begin
      cat_d = php_pkg::CatAcid;
    end else if (ph_d <= php_pkg::PhEight) begin
      cat_d = php_pkg::CatNeutral;
    end else begin
      cat_d = php_pkg::CatBase;
    end

    // converter error overrides everything
    if (quo.err) begin
      ph_d  = '0;
      cat_d = php_pkg::CatError;
    end
  end

  assign out_rdy = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      ph_q  <= ph_d;
      cat_q <= cat_d;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.ph_value = ph_q;
  assign out_o.category = cat_q;

endmodule

`default_nettype wire
